// ===== rtl/assert_macros.svh =====
// assertion macros used by the rtl top level
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication under synchronous active-low reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication under synchronous active-low reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sha1_pkg.sv =====
// sha1 digest package: constants, command and status types
// no dependencies
package sha1_pkg;

    localparam int unsigned NUM_WORDS = 5;
    localparam logic [2:0]  LAST_WORD_IDX = 3'd4;
    localparam logic [6:0]  LAST_ROUND = 7'd79;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // byte source codes for the block buffer
    localparam logic [1:0] SRC_IN   = 2'd0;
    localparam logic [1:0] SRC_PAD  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;
    localparam logic [1:0] SRC_LEN  = 2'd3;

    typedef struct packed {
        logic       load;
        logic [1:0] src;
        logic [2:0] len_idx;
        logic       count_bits;
        logic       work_init;
        logic       round_en;
        logic [6:0] round;
        logic       chain_add;
        logic       msg_clear;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic at56;
    } t_stat;

endpackage

// ===== rtl/sha1_if.sv =====
// handshake interfaces for the byte input and digest output channels
// no dependencies
interface sha1_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;

    modport source (output valid, output data_byte, output has_byte,
                    output end_of_message, input ready);
    modport sink (input valid, input data_byte, input has_byte,
                  input end_of_message, output ready);
endinterface

interface sha1_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, output ready);
endinterface

// ===== rtl/sha1_dp.sv =====
// sha1 datapath: block buffer as schedule shift line, round unit, chain words
// depends on sha1_pkg
module sha1_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sha1_pkg::t_cmd   i_cmd,
    input  logic [7:0]       i_data_byte,
    input  logic [2:0]       i_word_idx,
    output sha1_pkg::t_stat  o_stat,
    output logic [31:0]      o_digest_word
);
    import sha1_pkg::*;

    logic [511:0] r_buf;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [31:0]  r_h [NUM_WORDS];
    logic [6:0]   r_fill;
    logic [63:0]  r_bits;

    logic [7:0]   s_byte;
    logic [63:0]  s_len_shift;
    logic [31:0]  s_q0, s_q2, s_q8, s_q13, s_x, s_w;
    logic [31:0]  s_f, s_k, s_t;
    logic [31:0]  s_work [NUM_WORDS];

    // length bytes go out most significant first
    assign s_len_shift = r_bits >> {3'd7 - i_cmd.len_idx, 3'b000};

    always_comb begin
        case (i_cmd.src)
            SRC_IN:   s_byte = i_data_byte;
            SRC_PAD:  s_byte = PAD_BYTE;
            SRC_ZERO: s_byte = 8'h00;
            default:  s_byte = s_len_shift[7:0];
        endcase
    end

    // schedule taps: word i of the window sits at r_buf[511-32i -: 32]
    assign s_q0  = r_buf[511:480];
    assign s_q2  = r_buf[447:416];
    assign s_q8  = r_buf[255:224];
    assign s_q13 = r_buf[95:64];
    assign s_x   = s_q13 ^ s_q8 ^ s_q2 ^ s_q0;
    assign s_w   = (i_cmd.round < 7'd16) ? s_q0 : {s_x[30:0], s_x[31]};

    always_comb begin
        if (i_cmd.round < 7'd20) begin
            s_f = (r_b & r_c) | (~r_b & r_d);
            s_k = K0;
        end else if (i_cmd.round < 7'd40) begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K1;
        end else if (i_cmd.round < 7'd60) begin
            s_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            s_k = K2;
        end else begin
            s_f = r_b ^ r_c ^ r_d;
            s_k = K3;
        end
    end

    assign s_t = {r_a[26:0], r_a[31:27]} + s_f + r_e + s_k + s_w;

    assign s_work[0] = r_a;
    assign s_work[1] = r_b;
    assign s_work[2] = r_c;
    assign s_work[3] = r_d;
    assign s_work[4] = r_e;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_buf <= {r_buf[503:0], s_byte};
        end else if (i_cmd.round_en) begin
            r_buf <= {r_buf[479:0], s_w};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.work_init) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_cmd.round_en) begin
            r_a <= s_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.msg_clear) begin
            r_h[0] <= IV0;
            r_h[1] <= IV1;
            r_h[2] <= IV2;
            r_h[3] <= IV3;
            r_h[4] <= IV4;
            r_fill <= '0;
            r_bits <= '0;
        end else begin
            if (i_cmd.chain_add) begin
                for (int i = 0; i < NUM_WORDS; i++) begin
                    r_h[i] <= r_h[i] + s_work[i];
                end
                r_fill <= '0;
            end else if (i_cmd.load) begin
                r_fill <= r_fill + 7'd1;
            end
            if (i_cmd.count_bits) begin
                r_bits <= r_bits + 64'd8;
            end
        end
    end

    assign o_stat.full = r_fill[6];
    assign o_stat.at56 = (r_fill == 7'd56);

    always_comb begin
        case (i_word_idx)
            3'd0:    o_digest_word = r_h[0];
            3'd1:    o_digest_word = r_h[1];
            3'd2:    o_digest_word = r_h[2];
            3'd3:    o_digest_word = r_h[3];
            default: o_digest_word = r_h[4];
        endcase
    end

endmodule

// ===== rtl/sha1_ctrl.sv =====
// sha1 controller: byte intake, padding sequence, round count, digest output
// depends on sha1_pkg
module sha1_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_has_byte,
    input  logic             i_end_of_message,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  sha1_pkg::t_stat  i_stat,
    output sha1_pkg::t_cmd   o_cmd,
    output logic [2:0]       o_word_idx
);
    import sha1_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    // padding phases
    localparam logic [1:0] P_FIRST = 2'd0;
    localparam logic [1:0] P_ZERO  = 2'd1;
    localparam logic [1:0] P_LEN   = 2'd2;

    logic [2:0] r_state, n_state;
    logic [1:0] r_phase, n_phase;
    logic [3:0] r_len, n_len;
    logic [6:0] r_round, n_round;
    logic [2:0] r_word, n_word;
    logic       r_eom, n_eom;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_phase = r_phase;
        n_len   = r_len;
        n_round = r_round;
        n_word  = r_word;
        n_eom   = r_eom;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load       = i_has_byte;
                    o_cmd.src        = SRC_IN;
                    o_cmd.count_bits = i_has_byte;
                    n_eom   = i_end_of_message;
                    n_phase = P_FIRST;
                    n_len   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.full) begin
                    o_cmd.work_init = 1'b1;
                    n_round = '0;
                    n_state = S_ROUND;
                end else if (!r_eom) begin
                    n_state = S_IDLE;
                end else if (r_phase == P_LEN && r_len[3]) begin
                    n_word  = '0;
                    n_state = S_OUT;
                end else begin
                    if (r_phase == P_ZERO && i_stat.at56) begin
                        n_phase = P_LEN;
                    end
                    n_state = S_PAD;
                end
            end
            S_PAD: begin
                o_cmd.load = 1'b1;
                case (r_phase)
                    P_FIRST: begin
                        o_cmd.src = SRC_PAD;
                        n_phase   = P_ZERO;
                    end
                    P_ZERO: begin
                        o_cmd.src = SRC_ZERO;
                    end
                    default: begin
                        o_cmd.src     = SRC_LEN;
                        o_cmd.len_idx = r_len[2:0];
                        n_len         = r_len + 4'd1;
                    end
                endcase
                n_state = S_CHECK;
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                o_cmd.round    = r_round;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                n_state = S_CHECK;
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (r_word == LAST_WORD_IDX) begin
                        o_cmd.msg_clear = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_word = r_word + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_FIRST;
            r_len   <= '0;
            r_round <= '0;
            r_word  <= '0;
            r_eom   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_len   <= n_len;
            r_round <= n_round;
            r_word  <= n_word;
            r_eom   <= n_eom;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign o_word_idx  = r_word;

endmodule

// ===== rtl/sha1_message_digest_top.sv =====
// sha1 digest top level: at most one message byte per item in, five digest words out
// an item passes the idle and check states; filling a 64-byte block adds the
//   compression (80 rounds on the single round unit, one chain add, one check)
// end of message: each pad byte passes the pad and check states, plus one or two block
//   compressions, then five words, one per cycle while the sink is ready
// reset: synchronous active low, chain words to the initial values, counts to zero
`include "assert_macros.svh"

module sha1_message_digest_top (
    input logic          i_clk,
    input logic          i_rst_n,
    sha1_in_if.sink      i_in,
    sha1_out_if.source   o_out
);
    import sha1_pkg::*;

    // command and status between controller and datapath
    t_cmd        s_cmd;
    t_stat       s_stat;
    logic [2:0]  s_word_idx;
    logic [31:0] s_digest_word;
    logic        s_last_taken;

    // controller: accepts an item only when idle, sequences padding and rounds
    sha1_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in.valid),
        .i_has_byte       (i_in.has_byte),
        .i_end_of_message (i_in.end_of_message),
        .o_in_ready       (i_in.ready),
        .o_out_valid      (o_out.valid),
        .i_out_ready      (o_out.ready),
        .i_stat           (s_stat),
        .o_cmd            (s_cmd),
        .o_word_idx       (s_word_idx)
    );

    // datapath: block buffer doubles as the rolling 16-word schedule window
    sha1_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_data_byte   (i_in.data_byte),
        .i_word_idx    (s_word_idx),
        .o_stat        (s_stat),
        .o_digest_word (s_digest_word)
    );

    // digest words leave h0 first
    assign o_out.digest_word = s_digest_word;
    assign o_out.word_index  = s_word_idx;
    assign o_out.last_word   = (s_word_idx == LAST_WORD_IDX);

    // last digest word taken by the sink
    assign s_last_taken = o_out.valid && o_out.ready && o_out.last_word;

    // no new item is taken while the digest is being delivered
    `ASSERT_IMPLY(a_no_intake_during_out, i_clk, i_rst_n, o_out.valid, !i_in.ready)
    // an accepted item always leaves the block busy in the next cycle
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // delivering the last word returns the block to idle
    `ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, s_last_taken, i_in.ready && !o_out.valid)
    // a full block is never left waiting while the digest is shown
    `ASSERT_IMPLY(a_no_full_at_out, i_clk, i_rst_n, o_out.valid, !s_stat.full)

endmodule
